FILE: sv/pol_pkg.sv
package pol_pkg;

	localparam int LIST_DEPTH  = 16;
	localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W       = $clog2(LIST_DEPTH);
	localparam int POS_W       = 8;
	localparam int VAL_W       = 32;
	localparam int OUT_CNT_W   = 5;
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic {
		OP_INS = 1'b0,
		OP_DEL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
	} cmd_t;

endpackage

FILE: sv/pol_ctrl.sv
module pol_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  logic                          op_s1,
	input  logic [pol_pkg::POS_W-1:0]     pos_s1,
	input  logic [pol_pkg::VAL_W-1:0]     val_s1,
	output pol_pkg::cmd_t                 cmd,
	output logic [pol_pkg::CNT_W-1:0]     count_next,
	output pol_pkg::status_t              status_next
);

	logic [pol_pkg::CNT_W-1:0] count_q;
	logic [pol_pkg::CMP_W-1:0] cnt_ext;
	logic [pol_pkg::CMP_W-1:0] pos_ext;
	logic [pol_pkg::CMP_W-1:0] lim;
	logic                      full;
	logic                      empty;
	logic                      is_del;

	assign cnt_ext = pol_pkg::CMP_W'(count_q);
	assign pos_ext = pol_pkg::CMP_W'(pos_s1);
	assign lim     = (pos_ext < cnt_ext) ? pos_ext : cnt_ext;
	assign full    = (count_q == pol_pkg::CNT_W'(pol_pkg::LIST_DEPTH));
	assign empty   = (count_q == '0);
	assign is_del  = (op_s1 == pol_pkg::OP_DEL);

	always_comb begin
		cmd.ins     = valid_s1 && !is_del && !full;
		cmd.del     = valid_s1 && is_del && !empty;
		cmd.val     = val_s1;
		status_next = pol_pkg::ST_DONE;
		if (is_del) begin
			cmd.idx = (lim == '0) ? '0 : pol_pkg::IDX_W'(lim - 1'b1);
			if (empty)
				status_next = pol_pkg::ST_EMPTY;
		end else begin
			cmd.idx = pol_pkg::IDX_W'(lim);
			if (full)
				status_next = pol_pkg::ST_FULL;
		end
	end

	always_comb begin
		count_next = count_q;
		if (cmd.ins)
			count_next = count_q + 1'b1;
		else if (cmd.del)
			count_next = count_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_next;
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pol_pkg::CNT_W'(pol_pkg::LIST_DEPTH))
		else $error("count beyond depth");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !is_del && full |=> $stable(count_q))
		else $error("dropped insert changed count");
	a_del_dec: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && is_del && !empty |=> count_q == $past(count_q) - 1'b1)
		else $error("delete did not decrement");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(count_q))
		else $error("count moved without item");
`endif

endmodule

FILE: sv/pol_cells.sv
module pol_cells (
	input  logic                          clk,
	input  pol_pkg::cmd_t                 cmd,
	input  logic [pol_pkg::CNT_W-1:0]     count_next,
	output logic [pol_pkg::VAL_W-1:0]     front,
	output logic [pol_pkg::VAL_W-1:0]     back
);

	logic [pol_pkg::VAL_W-1:0] ent_q [pol_pkg::LIST_DEPTH];
	logic [pol_pkg::VAL_W-1:0] nxt   [pol_pkg::LIST_DEPTH];
	logic [pol_pkg::IDX_W-1:0] back_idx;

	for (genvar i = 0; i < pol_pkg::LIST_DEPTH; i++) begin : g_cell
		logic [pol_pkg::VAL_W-1:0] from_lo;
		logic [pol_pkg::VAL_W-1:0] from_hi;

		if (i > 0) begin : g_lo
			assign from_lo = ent_q[i-1];
		end else begin : g_lo0
			assign from_lo = ent_q[i];
		end

		if (i < pol_pkg::LIST_DEPTH - 1) begin : g_hi
			assign from_hi = ent_q[i+1];
		end else begin : g_hi0
			assign from_hi = ent_q[i];
		end

		always_comb begin
			nxt[i] = ent_q[i];
			if (cmd.ins) begin
				if (pol_pkg::IDX_W'(i) == cmd.idx)
					nxt[i] = cmd.val;
				else if (pol_pkg::IDX_W'(i) > cmd.idx)
					nxt[i] = from_lo;
			end else if (cmd.del) begin
				if (pol_pkg::IDX_W'(i) >= cmd.idx)
					nxt[i] = from_hi;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.ins || cmd.del)
				ent_q[i] <= nxt[i];
		end
	end

	assign back_idx = pol_pkg::IDX_W'(count_next - 1'b1);
	assign front    = (count_next == '0) ? '0 : nxt[0];
	assign back     = (count_next == '0) ? '0 : nxt[back_idx];

endmodule

FILE: sv/positional_ordered_list_top.sv
// channel  signals                                   handshake
// input    start, operation, position, value         taken when start && !busy
// result   entry_count, list_empty, front_value,     done high one cycle
//          back_value, status
//
// One item per cycle; each start is registered into valid_s1 and its operands, and its result is registered from there.
// The list cells shift in parallel, so the next item sees the update at once.
// busy stays low: there is never a reason to refuse an item.
// Reset empties the list; the receiver cannot stall results.
module positional_ordered_list_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [pol_pkg::POS_W-1:0]     position,
	input  logic signed [pol_pkg::VAL_W-1:0] value,
	output logic                          done,
	output logic [pol_pkg::OUT_CNT_W-1:0] entry_count,
	output logic                          list_empty,
	output logic signed [pol_pkg::VAL_W-1:0] front_value,
	output logic signed [pol_pkg::VAL_W-1:0] back_value,
	output logic [1:0]                    status
);

	logic                       valid_s1;
	logic                       op_s1;
	logic [pol_pkg::POS_W-1:0]  pos_s1;
	logic [pol_pkg::VAL_W-1:0]  val_s1;
	pol_pkg::cmd_t              cmd;
	logic [pol_pkg::CNT_W-1:0]  count_next;
	pol_pkg::status_t           status_next;
	logic [pol_pkg::VAL_W-1:0]  front;
	logic [pol_pkg::VAL_W-1:0]  back;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1  <= operation;
			pos_s1 <= position;
			val_s1 <= value;
		end
	end

	pol_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.op_s1       (op_s1),
		.pos_s1      (pos_s1),
		.val_s1      (val_s1),
		.cmd         (cmd),
		.count_next  (count_next),
		.status_next (status_next)
	);

	pol_cells u_cells (
		.clk        (clk),
		.cmd        (cmd),
		.count_next (count_next),
		.front      (front),
		.back       (back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			entry_count <= pol_pkg::OUT_CNT_W'(count_next);
			list_empty  <= (count_next == '0);
			front_value <= front;
			back_value  <= back;
			status      <= status_next;
		end
	end

endmodule

FILE: sim/tb_positional_ordered_list_top.sv
`timescale 1ns / 1ps

module tb_positional_ordered_list_top;

	localparam int IDLE_LIMIT   = 100;
	localparam int DRAIN_CYCLES = 8;
	localparam logic signed [pol_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [pol_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [pol_pkg::OUT_CNT_W-1:0]    count;
		logic                             empty;
		logic signed [pol_pkg::VAL_W-1:0] front;
		logic signed [pol_pkg::VAL_W-1:0] back;
		pol_pkg::status_t                 status;
	} list_report_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic                             busy;
	logic                             operation = 1'b0;
	logic [pol_pkg::POS_W-1:0]        position = '0;
	logic signed [pol_pkg::VAL_W-1:0] value = '0;
	logic                             done;
	logic [pol_pkg::OUT_CNT_W-1:0]    entry_count;
	logic                             list_empty;
	logic signed [pol_pkg::VAL_W-1:0] front_value;
	logic signed [pol_pkg::VAL_W-1:0] back_value;
	logic [1:0]                       status;

	logic signed [pol_pkg::VAL_W-1:0] held_words [pol_pkg::LIST_DEPTH];
	int                               held_count = 0;
	list_report_t                     pending_reports [$];
	int                               errors = 0;
	int                               max_gap = 12;
	int                               idle_cycles = 0;

	positional_ordered_list_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.position    (position),
		.value       (value),
		.done        (done),
		.entry_count (entry_count),
		.list_empty  (list_empty),
		.front_value (front_value),
		.back_value  (back_value),
		.status      (status)
	);

	always #4 clk = ~clk;

	function automatic list_report_t apply_list_op(pol_pkg::op_t op,
			logic [pol_pkg::POS_W-1:0] pos, logic signed [pol_pkg::VAL_W-1:0] val);
		list_report_t r;
		int slot;
		r.status = pol_pkg::ST_DONE;
		if (op == pol_pkg::OP_INS) begin
			if (held_count >= pol_pkg::LIST_DEPTH) begin
				r.status = pol_pkg::ST_FULL;
			end else begin
				if (pos == 0)
					slot = 0;
				else if (int'(pos) >= held_count)
					slot = held_count;
				else
					slot = int'(pos);
				for (int i = held_count; i > slot; i--)
					held_words[i] = held_words[i-1];
				held_words[slot] = val;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = pol_pkg::ST_EMPTY;
			end else begin
				if (pos <= 1)
					slot = 0;
				else if (int'(pos) >= held_count)
					slot = held_count - 1;
				else
					slot = int'(pos) - 1;
				for (int i = slot; i + 1 < held_count; i++)
					held_words[i] = held_words[i+1];
				held_count--;
			end
		end
		r.count = held_count[pol_pkg::OUT_CNT_W-1:0];
		r.empty = (held_count == 0);
		r.front = (held_count == 0) ? '0 : held_words[0];
		r.back  = (held_count == 0) ? '0 : held_words[held_count-1];
		return r;
	endfunction

	// start stays high across back-to-back items
	task automatic send_item(pol_pkg::op_t op, logic [pol_pkg::POS_W-1:0] pos,
			logic signed [pol_pkg::VAL_W-1:0] val);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		position  <= pos;
		value     <= val;
		do @(posedge clk); while (busy);
		pending_reports.push_back(apply_list_op(op, pos, val));
	endtask

	task automatic test_empty_list();
		send_item(pol_pkg::OP_DEL, 8'd255, '0);
	endtask

	task automatic test_sole_element();
		send_item(pol_pkg::OP_INS, 8'd0, VAL_MAX);
		send_item(pol_pkg::OP_DEL, 8'd255, '0);
	endtask

	task automatic test_fill_to_capacity();
		logic [pol_pkg::POS_W-1:0]        pos;
		logic signed [pol_pkg::VAL_W-1:0] val;
		for (int i = 0; i < pol_pkg::LIST_DEPTH; i++) begin
			case (i % 4)
				0: pos = 8'd0;
				1: pos = 8'd255;
				2: pos = pol_pkg::POS_W'(held_count);
				default: pos = pol_pkg::POS_W'(held_count / 2);
			endcase
			case (i)
				0: val = VAL_MIN;
				1: val = VAL_MAX;
				2: val = '0;
				3: val = -1;
				default: val = $urandom;
			endcase
			send_item(pol_pkg::OP_INS, pos, val);
		end
		send_item(pol_pkg::OP_INS, 8'd0, $urandom);
	endtask

	task automatic test_delete_positions();
		send_item(pol_pkg::OP_DEL, 8'd0, '0);
		send_item(pol_pkg::OP_DEL, 8'd1, $urandom);
		send_item(pol_pkg::OP_DEL, 8'd7, '0);
		send_item(pol_pkg::OP_DEL, pol_pkg::POS_W'(held_count), '0);
		send_item(pol_pkg::OP_DEL, 8'd255, '0);
	endtask

	task automatic test_random_traffic();
		int                               ins_pct;
		pol_pkg::op_t                     op;
		logic [pol_pkg::POS_W-1:0]        pos;
		logic signed [pol_pkg::VAL_W-1:0] val;
		for (int phase = 0; phase < 15; phase++) begin
			// alternate filling and draining so both ends of the list are hit
			ins_pct = (phase % 5 == 4) ? 50 : ((phase % 2 == 0) ? 85 : 15);
			max_gap = (phase % 3 == 1) ? 0 : 12;
			for (int n = 0; n < 60; n++) begin
				op = ($urandom_range(0, 99) < ins_pct) ? pol_pkg::OP_INS : pol_pkg::OP_DEL;
				case ($urandom_range(0, 5))
					0: pos = 8'd0;
					1: pos = 8'd1;
					2: pos = pol_pkg::POS_W'(held_count);
					3: pos = pol_pkg::POS_W'(held_count - 1 + int'($urandom_range(0, 2)));
					4: pos = pol_pkg::POS_W'($urandom_range(0, pol_pkg::LIST_DEPTH + 1));
					default: pos = pol_pkg::POS_W'($urandom);
				endcase
				case ($urandom_range(0, 9))
					0: val = VAL_MIN;
					1: val = VAL_MAX;
					2: val = '0;
					default: val = $urandom;
				endcase
				send_item(op, pos, val);
			end
		end
	endtask

	always @(posedge clk) begin
		list_report_t want;
		if (arst_n && done) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: entry_count %0d status %0d", entry_count, status);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, actual %0d", want.count, entry_count);
					errors++;
				end
				if (list_empty !== want.empty) begin
					$error("list_empty: expected %0d, actual %0d", want.empty, list_empty);
					errors++;
				end
				if (front_value !== want.front) begin
					$error("front_value: expected %0d, actual %0d", want.front, front_value);
					errors++;
				end
				if (back_value !== want.back) begin
					$error("back_value: expected %0d, actual %0d", want.back, back_value);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("positional_ordered_list_top verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_sole_element();
		test_fill_to_capacity();
		test_delete_positions();
		test_random_traffic();
		start <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("positional_ordered_list_top verification clean");
		else
			$display("positional_ordered_list_top verification failed");
		$finish;
	end

endmodule
